/* hw/rtl/sms_pkg.sv */
`default_nettype none

package sms_pkg;

	localparam int unsigned DATA_BITS  = 8;
	localparam int unsigned EDGE_BITS  = $clog2(2 * DATA_BITS);
	localparam int unsigned PRE_BITS   = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 3;

	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [EDGE_BITS-1:0] edge_cnt_t;
	typedef logic [PRE_BITS-1:0]  pre_cnt_t;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE      = 3'd0,
		CFG_LSB_FIRST   = 3'd1,
		CFG_CLOCK_MODE  = 3'd2,
		CFG_RATE_SELECT = 3'd3,
		CFG_IRQ_ENABLE  = 3'd4
	} cfg_idx_t;

	localparam logic [2:0] RATE_RESET = 3'd3;

	localparam edge_cnt_t EDGE_LAST = edge_cnt_t'(2 * DATA_BITS - 1);

	// Half period of SCK in accepted tick requests for the two low rate bits.
	localparam pre_cnt_t HALF_BASE [4] = '{7'd2, 7'd8, 7'd32, 7'd64};

	function automatic data_t shift_in(input data_t sr, input logic bit_in,
	                                   input logic lsb_first);
		if (lsb_first) begin
			return {bit_in, sr[DATA_BITS-1:1]};
		end
		return {sr[DATA_BITS-2:0], bit_in};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/spi_master_shift_engine.sv */
// Channel   Handshake                Payload
// input     in_valid / in_stall      mode, write_data, miso
// output    out_valid / out_stall    sck, mosi, read_data, transfer_done,
//                                    busy_res, interrupt_request
// config    cfg_write_enable         cfg_index, cfg_write_data
//
// Each accepted request is processed and its result appears in the result register
// on the following cycle, so one request is taken every cycle while in_stall is low.
// The engine state and the result register are loaded at the same clock edge.
// in_stall is raised only while the result register holds an untaken result
// and out_stall is high. Reset clears the engine state and returns the
// configuration to its reset values.
`default_nettype none

module spi_master_shift_engine (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [1:0]                          mode,
	input  wire  [sms_pkg::DATA_BITS-1:0]       write_data,
	input  wire                                 miso,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                sck,
	output logic                                mosi,
	output logic [sms_pkg::DATA_BITS-1:0]       read_data,
	output logic                                transfer_done,
	output logic                                busy_res,
	output logic                                interrupt_request,
	input  wire                                 cfg_write_enable,
	input  wire  [sms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [sms_pkg::CFG_DATA_W-1:0]      cfg_write_data
);
	import sms_pkg::*;

	logic       enable_q;
	logic       lsb_first_q;
	logic [1:0] clock_mode_q;
	logic [2:0] rate_select_q;
	logic       irq_enable_q;

	data_t     shift_q,    shift_n;
	edge_cnt_t edge_q,     edge_n;
	pre_cnt_t  prescale_q, prescale_n;
	logic      clock_level_q, clock_level_n;
	data_t     received_q, received_n;
	logic      done_q,     done_n;
	logic      active_q,   active_n;
	logic      sampled_q,  sampled_n;

	logic                accept;
	pre_cnt_t            half_period;
	logic [PRE_BITS:0]   prescale_inc;
	logic                edge_due;
	logic                leading;
	logic                last_edge;
	logic                sck_n;
	logic                mosi_n;

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			lsb_first_q   <= 1'b0;
			clock_mode_q  <= 2'd0;
			rate_select_q <= RATE_RESET;
			irq_enable_q  <= 1'b0;
		end else if (cfg_write_enable) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:      enable_q      <= cfg_write_data[0];
				CFG_LSB_FIRST:   lsb_first_q   <= cfg_write_data[0];
				CFG_CLOCK_MODE:  clock_mode_q  <= cfg_write_data[1:0];
				CFG_RATE_SELECT: rate_select_q <= cfg_write_data[2:0];
				CFG_IRQ_ENABLE:  irq_enable_q  <= cfg_write_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		half_period = HALF_BASE[rate_select_q[1:0]];
		if (rate_select_q[2]) begin
			half_period = half_period >> 1;
		end
		prescale_inc = {1'b0, prescale_q} + {{PRE_BITS{1'b0}}, 1'b1};
		edge_due     = prescale_inc >= {1'b0, half_period};
		leading      = ~edge_q[0];
		last_edge    = edge_q == EDGE_LAST;
	end

	always_comb begin
		shift_n       = shift_q;
		edge_n        = edge_q;
		prescale_n    = prescale_q;
		clock_level_n = clock_level_q;
		received_n    = received_q;
		done_n        = done_q;
		active_n      = active_q;
		sampled_n     = sampled_q;

		unique case (mode_t'(mode))
			MODE_TICK: begin
				if (active_q && !enable_q) begin
					active_n      = 1'b0;
					edge_n        = '0;
					prescale_n    = '0;
					clock_level_n = clock_mode_q[1];
				end else if (active_q) begin
					if (edge_due) begin
						prescale_n    = '0;
						clock_level_n = ~clock_level_q;
						if (!clock_mode_q[0]) begin
							if (leading) begin
								sampled_n = miso;
							end else begin
								shift_n = shift_in(shift_q, sampled_q, lsb_first_q);
							end
						end else begin
							if (leading) begin
								if (edge_q != '0) begin
									shift_n = shift_in(shift_q, sampled_q, lsb_first_q);
								end
							end else begin
								sampled_n = miso;
								if (last_edge) begin
									shift_n = shift_in(shift_q, miso, lsb_first_q);
								end
							end
						end
						edge_n = edge_q + edge_cnt_t'(1);
						if (last_edge) begin
							received_n    = shift_n;
							done_n        = 1'b1;
							active_n      = 1'b0;
							edge_n        = '0;
							clock_level_n = clock_mode_q[1];
						end
					end else begin
						prescale_n = prescale_inc[PRE_BITS-1:0];
					end
				end
			end
			MODE_WRITE: begin
				if (enable_q && !active_q) begin
					shift_n       = write_data;
					active_n      = 1'b1;
					edge_n        = '0;
					prescale_n    = '0;
					clock_level_n = clock_mode_q[1];
				end
			end
			MODE_READ: begin
				done_n = 1'b0;
			end
			default: ;
		endcase

		sck_n  = active_n ? clock_level_n : clock_mode_q[1];
		mosi_n = active_n & (lsb_first_q ? shift_n[0] : shift_n[DATA_BITS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q       <= '0;
			edge_q        <= '0;
			prescale_q    <= '0;
			clock_level_q <= 1'b0;
			received_q    <= '0;
			done_q        <= 1'b0;
			active_q      <= 1'b0;
			sampled_q     <= 1'b0;
		end else if (accept) begin
			shift_q       <= shift_n;
			edge_q        <= edge_n;
			prescale_q    <= prescale_n;
			clock_level_q <= clock_level_n;
			received_q    <= received_n;
			done_q        <= done_n;
			active_q      <= active_n;
			sampled_q     <= sampled_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sck               <= sck_n;
			mosi              <= mosi_n;
			read_data         <= received_n;
			transfer_done     <= done_n;
			busy_res          <= active_n;
			interrupt_request <= done_n & irq_enable_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sms_checker.sv */
`default_nettype none

module sms_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire [1:0]                        mode,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire                              mosi,
	input wire [sms_pkg::DATA_BITS-1:0]     read_data,
	input wire                              transfer_done,
	input wire                              busy_res,
	input wire                              interrupt_request
);
	import sms_pkg::*;

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(busy_res))
		else $error("stalled result changed");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	a_irq_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && interrupt_request |-> transfer_done)
		else $error("interrupt request without done flag");

	a_idle_mosi_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !mosi)
		else $error("mosi driven while idle");

	a_read_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_READ |=> out_valid && !transfer_done)
		else $error("read request left done flag set");

endmodule

bind spi_master_shift_engine sms_checker u_sms_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.mode              (mode),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.mosi              (mosi),
	.read_data         (read_data),
	.transfer_done     (transfer_done),
	.busy_res          (busy_res),
	.interrupt_request (interrupt_request)
);

`default_nettype wire
